// ===== rtl/ecc_pkg.sv =====
package ecc_pkg;

    // floor count and field widths
    localparam int FLOORS  = 16;
    localparam int FLOOR_W = 4;
    localparam int CMD_W   = 3;
    localparam int ACT_W   = 3;
    localparam int CNT_W   = 6;
    localparam int ID_W    = 8;

    // floor numbers at or above this are dropped
    localparam logic [FLOOR_W:0] FLOOR_LIMIT = (FLOOR_W + 1)'(FLOORS);

    localparam logic [ID_W-1:0] CAR_LETTER_RST = 8'd101;

    // event commands
    localparam logic [CMD_W-1:0] CMD_HALL   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CAB    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OPENED = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PASSED = 3'd4;

    // result actions
    localparam logic [ACT_W-1:0] ACT_OPEN  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLOSE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DOWN  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_LON   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_LOFF  = 3'd6;

    // car modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WAIT = 2'd1;
    localparam logic [1:0] MODE_MOVE = 2'd2;
    localparam logic [1:0] MODE_REQ  = 2'd3;

    // travel directions
    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_STOP = 2'd2;

    // pending call kinds per floor
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_CAB  = 2'd1;
    localparam logic [1:0] PEND_UP   = 2'd2;
    localparam logic [1:0] PEND_DOWN = 2'd3;

    // result slots per event
    localparam int RES_SLOTS = 4;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [FLOOR_W-1:0] floor;
        logic               call_up;
    } t_event;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [FLOOR_W-1:0] button_floor;
    } t_res;

    typedef struct packed {
        logic [1:0]                 cnt;
        t_res [RES_SLOTS-1:0]       res;
    } t_batch;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] dir;
    } t_status;

    // saturating step of a six-bit signed count
    function automatic logic signed [CNT_W-1:0] sat_step(
        input logic signed [CNT_W-1:0] c,
        input logic                    dec
    );
        logic signed [CNT_W-1:0] r;
        r = c;
        if (dec) begin
            if (c != -6'sd32) r = c - 6'sd1;
        end else begin
            if (c != 6'sd31) r = c + 6'sd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ecc_core.sv =====
module ecc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_commit,
    input  ecc_pkg::t_event i_event,
    output ecc_pkg::t_batch o_batch,
    output ecc_pkg::t_status o_status
);
    import ecc_pkg::*;

    logic [1:0]              r_pend [FLOORS];
    logic [1:0]              r_mode;
    logic [1:0]              r_dir;
    logic [FLOOR_W-1:0]      r_pos;
    logic signed [CNT_W-1:0] r_above;
    logic signed [CNT_W-1:0] r_below;

    logic [1:0]              n_mode;
    logic [1:0]              n_dir;
    logic [FLOOR_W-1:0]      n_pos;
    logic signed [CNT_W-1:0] n_above;
    logic signed [CNT_W-1:0] n_below;
    logic                    pend_we;
    logic [1:0]              pend_val;
    logic [1:0]              p;
    logic [1:0]              k;
    logic                    legal;
    logic                    call_go;
    logic                    call_light;
    logic [1:0]              call_code;
    logic                    serve_go;
    logic                    serve_stop;
    logic                    go_up;
    t_batch                  batch;

    assign p = r_pend[i_event.floor];

    // event decode, call bookkeeping and movement decision
    always_comb begin
        n_mode     = r_mode;
        n_dir      = r_dir;
        n_pos      = r_pos;
        n_above    = r_above;
        n_below    = r_below;
        pend_we    = 1'b0;
        pend_val   = PEND_NONE;
        k          = 2'd0;
        batch      = '0;
        call_go    = 1'b0;
        call_light = 1'b0;
        call_code  = PEND_NONE;
        serve_go   = 1'b0;
        serve_stop = 1'b0;
        go_up      = 1'b0;

        legal = (i_event.command <= CMD_PASSED) &&
                !(((i_event.command == CMD_HALL) || (i_event.command == CMD_CAB) ||
                   (i_event.command == CMD_PASSED)) &&
                  ({1'b0, i_event.floor} >= FLOOR_LIMIT));

        if (legal) begin
            unique case (i_event.command)
                CMD_HALL: begin
                    if (p == PEND_NONE) begin
                        call_go   = 1'b1;
                        call_code = i_event.call_up ? PEND_UP : PEND_DOWN;
                    end
                end
                CMD_CAB: begin
                    if (p == PEND_UP || p == PEND_DOWN) begin
                        pend_we  = 1'b1;
                        pend_val = PEND_CAB;
                        batch.res[k] = '{ACT_LON, i_event.floor};
                        k = k + 2'd1;
                    end else if (p == PEND_NONE) begin
                        call_go    = 1'b1;
                        call_light = 1'b1;
                        call_code  = PEND_CAB;
                    end
                end
                CMD_OPENED: begin
                    batch.res[k] = '{ACT_LOFF, r_pos};
                    k = k + 2'd1;
                    batch.res[k] = '{ACT_CLOSE, {FLOOR_W{1'b0}}};
                    k = k + 2'd1;
                end
                CMD_CLOSED: begin
                    n_mode = MODE_REQ;
                end
                CMD_PASSED: begin
                    // clamped one-floor move in the current direction
                    if (r_dir == DIR_DOWN && r_pos != '0) n_pos = r_pos - 1'b1;
                    if (r_dir == DIR_UP && (({1'b0, r_pos} + 1'b1) < FLOOR_LIMIT))
                        n_pos = r_pos + 1'b1;
                    if ((p == PEND_UP && r_dir == DIR_UP) ||
                        (p == PEND_DOWN && r_dir == DIR_DOWN) || p == PEND_CAB) begin
                        serve_go   = 1'b1;
                        serve_stop = 1'b1;
                    end else if ((p == PEND_UP && r_dir == DIR_DOWN && r_above == '0) ||
                                 (p == PEND_DOWN && r_dir == DIR_UP && r_below == '0)) begin
                        serve_go = 1'b1;
                    end else if (p == PEND_UP && r_dir == DIR_DOWN) begin
                        n_above = sat_step(r_above, 1'b0);
                        n_below = sat_step(r_below, 1'b1);
                    end else if (p == PEND_DOWN && r_dir == DIR_UP) begin
                        n_below = sat_step(r_below, 1'b0);
                        n_above = sat_step(r_above, 1'b1);
                    end
                end
                default: begin
                end
            endcase

            // new call above, below or at the car
            if (call_go) begin
                if (i_event.floor > r_pos) begin
                    if (call_light) begin
                        batch.res[k] = '{ACT_LON, i_event.floor};
                        k = k + 2'd1;
                    end
                    n_above  = sat_step(r_above, 1'b0);
                    pend_we  = 1'b1;
                    pend_val = call_code;
                end else if (i_event.floor < r_pos) begin
                    if (call_light) begin
                        batch.res[k] = '{ACT_LON, i_event.floor};
                        k = k + 2'd1;
                    end
                    n_below  = sat_step(r_below, 1'b0);
                    pend_we  = 1'b1;
                    pend_val = call_code;
                end else begin
                    if (!call_light) begin
                        pend_we  = 1'b1;
                        pend_val = call_code;
                    end
                    if (n_mode == MODE_IDLE) begin
                        batch.res[k] = '{ACT_OPEN, {FLOOR_W{1'b0}}};
                        k = k + 2'd1;
                        n_mode = MODE_WAIT;
                    end
                end
                if (n_mode == MODE_IDLE) n_mode = MODE_REQ;
            end

            // stop at the floor being served
            if (serve_go) begin
                pend_we  = 1'b1;
                pend_val = PEND_NONE;
                if (n_dir == DIR_DOWN) n_below = sat_step(n_below, 1'b1);
                if (n_dir == DIR_UP) n_above = sat_step(n_above, 1'b1);
                if (serve_stop || n_pos != '0) begin
                    batch.res[k] = '{ACT_STOP, {FLOOR_W{1'b0}}};
                    k = k + 2'd1;
                end
                batch.res[k] = '{ACT_OPEN, {FLOOR_W{1'b0}}};
                k = k + 2'd1;
                n_mode = MODE_WAIT;
            end

            // collective movement decision
            if ((n_below > 6'sd0 || n_above > 6'sd0) && n_mode == MODE_REQ) begin
                if (n_dir == DIR_UP && n_above > 6'sd0) go_up = 1'b1;
                else if (n_dir == DIR_DOWN && n_below > 6'sd0) go_up = 1'b0;
                else if (n_dir == DIR_UP) go_up = 1'b0;
                else if (n_dir == DIR_DOWN) go_up = 1'b1;
                else go_up = (n_above > 6'sd0);
                n_dir = go_up ? DIR_UP : DIR_DOWN;
                batch.res[k] = '{(go_up ? ACT_UP : ACT_DOWN), {FLOOR_W{1'b0}}};
                k = k + 2'd1;
                n_mode = MODE_MOVE;
            end else if ((n_mode == MODE_WAIT || n_mode == MODE_IDLE) &&
                         n_below == '0 && n_above == '0) begin
                n_dir  = DIR_STOP;
                n_mode = MODE_IDLE;
            end
        end
        batch.cnt = k;
    end

    // car state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FLOORS; i++) r_pend[i] <= PEND_NONE;
            r_mode  <= MODE_IDLE;
            r_dir   <= DIR_STOP;
            r_pos   <= '0;
            r_above <= '0;
            r_below <= '0;
        end else if (i_commit) begin
            if (pend_we) r_pend[i_event.floor] <= pend_val;
            r_mode  <= n_mode;
            r_dir   <= n_dir;
            r_pos   <= n_pos;
            r_above <= n_above;
            r_below <= n_below;
        end
    end

    assign o_batch  = batch;
    assign o_status = '{r_mode, r_dir};

endmodule

// ===== rtl/ecc_res_buf.sv =====
module ecc_res_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  ecc_pkg::t_batch             i_batch,
    output logic                        o_free,
    output logic                        o_valid,
    input  logic                        i_ready,
    output ecc_pkg::t_res               o_res,
    output logic                        o_last
);
    import ecc_pkg::*;

    t_batch     r_batch;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       take;

    // current slot and last-slot flag
    assign o_valid = (r_idx < r_cnt);
    assign o_last  = ((r_idx + 2'd1) == r_cnt);
    assign o_res   = r_batch.res[r_idx];
    assign take    = o_valid && i_ready;
    assign o_free  = !o_valid || (take && o_last);

    // batch payload
    always_ff @(posedge i_clk) begin
        if (i_load) r_batch <= i_batch;
    end

    // slot counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
            r_idx <= '0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ===== rtl/elevator_car_controller_top.sv =====
// channel    | dir | tvalid/tready            | payload
// event in   | in  | i_s_axis_tvalid/o_..rdy  | tuser command, tdata floor, call_up
// command out| out | o_m_axis_tvalid/i_..rdy  | tuser action, tdata floor, car_id, tlast
// config     | in  | i_cfg_wr_en              | i_cfg_wr_data car letter
//
// an event is registered, then decoded combinationally against the car state;
// its commands (zero to two) leave one per cycle from the result buffer while tready is high
// the next event's batch loads in the cycle the previous batch's last command
// is taken; synchronous active-low reset clears the call table, mode, direction,
// position and counts; output stalls back up through the event register to
// o_s_axis_tready
module elevator_car_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [3:0] floor, [4] call_up, [7:5] zero
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [3:0] button_floor, [11:4] car_id, [15:12] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] action
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);
    import ecc_pkg::*;

    logic            r_in_valid;
    t_event          r_in;
    logic [ID_W-1:0] r_car_letter;
    logic            commit;
    logic            buf_free;
    logic            s_take;
    t_batch          batch;
    t_status         status;
    t_res            res;

    assign commit          = r_in_valid && buf_free;
    assign o_s_axis_tready = !r_in_valid || commit;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;

    // event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (commit) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) r_in <= '{i_s_axis_tuser, i_s_axis_tdata[3:0], i_s_axis_tdata[4]};
    end

    // car letter register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_letter <= CAR_LETTER_RST;
        end else if (i_cfg_wr_en) begin
            r_car_letter <= i_cfg_wr_data;
        end
    end

    ecc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_event  (r_in),
        .o_batch  (batch),
        .o_status (status)
    );

    ecc_res_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (commit),
        .i_batch (batch),
        .o_free  (buf_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res),
        .o_last  (o_m_axis_tlast)
    );

    // command framing
    assign o_m_axis_tuser = res.action;
    assign o_m_axis_tdata = {4'd0, r_car_letter, res.button_floor};

    // a held event is never dropped
    a_hold_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !commit) |=> r_in_valid)
        else $error("event register lost a pending request");

    // a batch with commands shows up at the output
    a_batch_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && batch.cnt != 2'd0) |=> o_m_axis_tvalid)
        else $error("loaded commands not presented");

    // a moving car always has a travel direction
    a_move_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.mode == MODE_MOVE) |-> (status.dir != DIR_STOP))
        else $error("car moving without direction");

    // no new batch while unsent commands remain
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !commit)
        else $error("result batch overwritten");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ecc_pkg::*;

    // commands the block must drop without a result
    localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 5;
    localparam int PHASE_EVENTS  = 390;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [FLOOR_W-1:0] button_floor;
        logic [ID_W-1:0]    car_id;
        logic               last;
    } t_car_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;    // [3:0] floor, [4] call_up, [7:5] zero
    logic [2:0]  i_s_axis_tuser = '0;    // [2:0] command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;         // [3:0] button_floor, [11:4] car_id, [15:12] zero
    logic [2:0]  o_m_axis_tuser;         // [2:0] action
    logic        o_m_axis_tlast;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;

    elevator_car_controller_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    // car state as predicted from accepted events
    logic [1:0]      call_tbl [FLOORS];
    logic [1:0]      car_mode_q = MODE_IDLE;
    logic [1:0]      car_dir    = DIR_STOP;
    logic [3:0]      car_pos    = '0;
    int              n_above    = 0;
    int              n_below    = 0;
    logic [ID_W-1:0] car_letter_q = CAR_LETTER_RST;

    t_car_cmd step_out [4];
    int       step_n;

    t_event   events_to_send [$];
    t_car_cmd cmds_due [$];
    t_event   ev_on_bus = '0;
    t_event   ev_next;
    bit       no_gaps = 1'b0;
    int       mismatches = 0;

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // six-bit signed count with saturation
    function automatic int sat_count(int c, int d);
        int v;
        v = c + d;
        if (v > 31) v = 31;
        if (v < -32) v = -32;
        return v;
    endfunction

    function automatic void add_cmd(logic [ACT_W-1:0] act, logic [FLOOR_W-1:0] fl);
        step_out[step_n] = '{action: act, button_floor: fl, car_id: car_letter_q, last: 1'b0};
        step_n++;
    endfunction

    // record a new call relative to the car position
    function automatic void log_call(logic [3:0] f, logic [1:0] kind, bit light);
        if (f > car_pos) begin
            if (light) add_cmd(ACT_LON, f);
            n_above = sat_count(n_above, 1);
            call_tbl[f] = kind;
        end else if (f < car_pos) begin
            if (light) add_cmd(ACT_LON, f);
            n_below = sat_count(n_below, 1);
            call_tbl[f] = kind;
        end else begin
            if (!light) call_tbl[f] = kind;
            if (car_mode_q == MODE_IDLE) begin
                add_cmd(ACT_OPEN, '0);
                car_mode_q = MODE_WAIT;
            end
        end
        if (car_mode_q == MODE_IDLE) car_mode_q = MODE_REQ;
    endfunction

    // stop at a floor and open the door
    function automatic void serve_floor(logic [3:0] f, bit always_stop);
        call_tbl[f] = PEND_NONE;
        if (car_dir == DIR_DOWN) n_below = sat_count(n_below, -1);
        if (car_dir == DIR_UP) n_above = sat_count(n_above, -1);
        if (always_stop || car_pos != 0) add_cmd(ACT_STOP, '0);
        add_cmd(ACT_OPEN, '0);
        car_mode_q = MODE_WAIT;
    endfunction

    // apply one event to the car state and queue the commands it causes
    function automatic void dispatch_event(t_event ev);
        logic [1:0] p;
        logic       go_up;
        int         i;
        step_n = 0;
        if (ev.command > CMD_PASSED) return;
        case (ev.command)
            CMD_HALL: begin
                if (call_tbl[ev.floor] == PEND_NONE)
                    log_call(ev.floor, ev.call_up ? PEND_UP : PEND_DOWN, 1'b0);
            end
            CMD_CAB: begin
                if (call_tbl[ev.floor] == PEND_UP || call_tbl[ev.floor] == PEND_DOWN) begin
                    call_tbl[ev.floor] = PEND_CAB;
                    add_cmd(ACT_LON, ev.floor);
                end
                if (call_tbl[ev.floor] == PEND_NONE) log_call(ev.floor, PEND_CAB, 1'b1);
            end
            CMD_OPENED: begin
                add_cmd(ACT_LOFF, car_pos);
                add_cmd(ACT_CLOSE, '0);
            end
            CMD_CLOSED: begin
                car_mode_q = MODE_REQ;
            end
            default: begin
                p = call_tbl[ev.floor];
                if (car_dir == DIR_DOWN && car_pos > 0) car_pos = car_pos - 1'b1;
                if (car_dir == DIR_UP && car_pos < FLOORS - 1) car_pos = car_pos + 1'b1;
                if ((p == PEND_UP && car_dir == DIR_UP) ||
                    (p == PEND_DOWN && car_dir == DIR_DOWN) || p == PEND_CAB) begin
                    serve_floor(ev.floor, 1'b1);
                end else if ((p == PEND_UP && car_dir == DIR_DOWN && n_above == 0) ||
                             (p == PEND_DOWN && car_dir == DIR_UP && n_below == 0)) begin
                    serve_floor(ev.floor, 1'b0);
                end else if (p == PEND_UP && car_dir == DIR_DOWN) begin
                    n_above = sat_count(n_above, 1);
                    n_below = sat_count(n_below, -1);
                end else if (p == PEND_DOWN && car_dir == DIR_UP) begin
                    n_below = sat_count(n_below, 1);
                    n_above = sat_count(n_above, -1);
                end
            end
        endcase

        // collective movement decision
        if ((n_below > 0 || n_above > 0) && car_mode_q == MODE_REQ) begin
            if (car_dir == DIR_UP && n_above > 0) go_up = 1'b1;
            else if (car_dir == DIR_DOWN && n_below > 0) go_up = 1'b0;
            else if (car_dir == DIR_UP) go_up = 1'b0;
            else if (car_dir == DIR_DOWN) go_up = 1'b1;
            else go_up = (n_above > 0);
            car_dir = go_up ? DIR_UP : DIR_DOWN;
            add_cmd(go_up ? ACT_UP : ACT_DOWN, '0);
            car_mode_q = MODE_MOVE;
        end else if ((car_mode_q == MODE_WAIT || car_mode_q == MODE_IDLE) &&
                     n_below == 0 && n_above == 0) begin
            car_dir = DIR_STOP;
            car_mode_q = MODE_IDLE;
        end

        if (step_n > 0) step_out[step_n-1].last = 1'b1;
        for (i = 0; i < step_n; i++) cmds_due.push_back(step_out[i]);
    endfunction

    // event driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) dispatch_event(ev_on_bus);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (events_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= 15)) begin
                    ev_next = events_to_send.pop_front();
                    ev_on_bus <= ev_next;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {3'b000, ev_next.call_up, ev_next.floor};
                    i_s_axis_tuser <= ev_next.command;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // command monitor
    always @(posedge i_clk) begin
        t_car_cmd want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (cmds_due.size() == 0) begin
                    $error("unexpected command: action %0d tdata %h", o_m_axis_tuser,
                           o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = cmds_due.pop_front();
                    if (o_m_axis_tuser != want.action) begin
                        $error("action: expected %0d, got %0d", want.action, o_m_axis_tuser);
                        mismatches++;
                    end
                    if (o_m_axis_tdata[3:0] != want.button_floor) begin
                        $error("button_floor: expected %0d, got %0d", want.button_floor,
                               o_m_axis_tdata[3:0]);
                        mismatches++;
                    end
                    if (o_m_axis_tdata[11:4] != want.car_id) begin
                        $error("car_id: expected %h, got %h", want.car_id, o_m_axis_tdata[11:4]);
                        mismatches++;
                    end
                    if (o_m_axis_tlast != want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            i_m_axis_tready <= no_gaps || ($urandom_range(99) >= 15);
        end
    end

    // watchdog on cycles without any accepted request or command
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic queue_event(logic [CMD_W-1:0] cmd, logic [3:0] fl, logic up);
        while (events_to_send.size() != 0) @(negedge i_clk);
        events_to_send.push_back('{command: cmd, floor: fl, call_up: up});
    endtask

    // wait until every command is out, then let the block settle
    task automatic drain();
        while (events_to_send.size() != 0 || i_s_axis_tvalid || cmds_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_car_letter(logic [7:0] v);
        drain();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        car_letter_q = v;
        @(negedge i_clk);
    endtask

    // floor for a floor-passed report: mostly a floor with a call or the car's next floor
    function automatic logic [3:0] pick_pass_floor();
        logic [3:0] busy [$];
        int         r;
        for (int i = 0; i < FLOORS; i++)
            if (call_tbl[i] != PEND_NONE) busy.push_back(4'(i));
        r = $urandom_range(99);
        if (r < 50 && busy.size() != 0) return busy[$urandom_range(busy.size() - 1)];
        if (r < 80) begin
            if (car_dir == DIR_UP) return (car_pos == FLOORS - 1) ? car_pos : car_pos + 1'b1;
            if (car_dir == DIR_DOWN) return (car_pos == 0) ? car_pos : car_pos - 1'b1;
            return car_pos;
        end
        return 4'($urandom_range(FLOORS - 1));
    endfunction

    // random traffic shaped like real car operation, with noise and long pass bursts
    task automatic run_traffic(int count);
        int         sent;
        int         r;
        int         k;
        logic [3:0] f;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 5) begin
                // repeated passes at one floor drive counts and position to their limits
                f = 4'($urandom_range(FLOORS - 1));
                k = $urandom_range(40, 10);
                repeat (k) queue_event(CMD_PASSED, f, 1'($urandom_range(1)));
                sent += k;
            end else if (r < 8) begin
                queue_event(3'($urandom_range(CMD_BAD_LAST, CMD_BAD_FIRST)),
                            4'($urandom_range(15)), 1'($urandom_range(1)));
            end else begin
                if (r < 33)
                    queue_event(CMD_HALL, 4'($urandom_range(FLOORS - 1)), 1'($urandom_range(1)));
                else if (r < 53)
                    queue_event(CMD_CAB, 4'($urandom_range(FLOORS - 1)), 1'($urandom_range(1)));
                else if (r < 63)
                    queue_event(CMD_OPENED, 4'($urandom_range(15)), 1'($urandom_range(1)));
                else if (r < 78)
                    queue_event(CMD_CLOSED, 4'($urandom_range(15)), 1'($urandom_range(1)));
                else
                    queue_event(CMD_PASSED, pick_pass_floor(), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // stimulus
    initial begin
        logic [7:0] letters [PHASES];
        foreach (call_tbl[i]) call_tbl[i] = PEND_NONE;
        letters[0] = 8'h00;
        letters[1] = 8'hFF;
        letters[2] = 8'h45;
        letters[3] = 8'($urandom_range(255));
        letters[4] = 8'h80;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk with the reset car letter
        queue_event(CMD_BAD_LAST, 4'd15, 1'b1);
        queue_event(CMD_BAD_FIRST, 4'd0, 1'b0);
        queue_event(CMD_HALL, 4'd0, 1'b0);      // call at the idle car's floor
        queue_event(CMD_OPENED, 4'd0, 1'b0);
        queue_event(CMD_CLOSED, 4'd15, 1'b1);
        queue_event(CMD_CAB, 4'd15, 1'b0);      // top floor, starts the car up
        queue_event(CMD_HALL, 4'd8, 1'b1);
        queue_event(CMD_CAB, 4'd8, 1'b1);       // cab call replaces a hall call
        queue_event(CMD_HALL, 4'd3, 1'b0);
        queue_event(CMD_HALL, 4'd1, 1'b1);
        queue_event(CMD_PASSED, 4'd1, 1'b0);    // hall up while going up
        queue_event(CMD_PASSED, 4'd8, 1'b0);
        queue_event(CMD_OPENED, 4'd8, 1'b0);
        queue_event(CMD_CLOSED, 4'd8, 1'b0);
        queue_event(CMD_PASSED, 4'd3, 1'b1);    // hall down with nothing below
        queue_event(CMD_CLOSED, 4'd3, 1'b0);
        queue_event(CMD_PASSED, 4'd15, 1'b1);
        queue_event(CMD_PASSED, 4'd15, 1'b0);   // repeated pass while the car is stopped

        for (int ph = 0; ph < PHASES; ph++) begin
            set_car_letter(letters[ph]);
            no_gaps = (ph == 2);
            run_traffic(PHASE_EVENTS);
        end
        drain();

        if (mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

// ===== elevator_car_controller_top.f =====
rtl/ecc_pkg.sv
rtl/ecc_core.sv
rtl/ecc_res_buf.sv
rtl/elevator_car_controller_top.sv
bench/testbench.sv
